@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/cabp_pkg.sv @@
// ----------------------------------------------------------------------------
// cabp_pkg
// Shared types and constants of the clipped alpha blend pixel block.
// ----------------------------------------------------------------------------
package cabp_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int INDEX_W    = 27;

  // Register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_ENABLE = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_LEFT   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_TOP    = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_SPAN_X = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_SPAN_Y = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_WIDTH    = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_HEIGHT   = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_PITCH    = 4'd7;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]  ALPHA_ZERO   = 8'h00;

  // n/255 == (n * 32897) >> 23 for every n up to 255*255
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int          DIV255_SHIFT = 23;

  // Per-stage advance strobes of the blend pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

endpackage

@@ hw/rtl/cabp_if.sv @@
// ----------------------------------------------------------------------------
// cabp_in_if / cabp_out_if
// Valid/ready channels for pixel requests and pixel write results.
// ----------------------------------------------------------------------------
interface cabp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [31:0]        src_color;
  logic [31:0]        dst_pixel;

  modport source (output valid, pos_x, pos_y, src_color, dst_pixel, input ready);
  modport sink   (input valid, pos_x, pos_y, src_color, dst_pixel, output ready);
endinterface

interface cabp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [cabp_pkg::INDEX_W-1:0] word_index;
  logic [31:0]                  out_pixel;

  modport source (output valid, write_enable, word_index, out_pixel, input ready);
  modport sink   (input valid, write_enable, word_index, out_pixel, output ready);
endinterface

@@ hw/rtl/cabp_chan.sv @@
// ----------------------------------------------------------------------------
// cabp_chan
// One color channel of the blend: (s*a + d*(255-a))/255 over three stages.
// ----------------------------------------------------------------------------
module cabp_chan (
  input  logic           clk,
  input  cabp_pkg::adv_t adv,
  input  logic [7:0]     s,
  input  logic [7:0]     d,
  input  logic [7:0]     a,
  output logic [7:0]     q
);

  logic [15:0] ps1;
  logic [15:0] pd1;
  logic [15:0] sum2;
  logic [31:0] prod3;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ps1 <= s * a;
      pd1 <= d * (cabp_pkg::ALPHA_OPAQUE - a);
    end
    if (adv.s2) begin
      sum2 <= ps1 + pd1;
    end
    // divide by 255 as a reciprocal multiply
    if (adv.s3) begin
      prod3 <= sum2 * cabp_pkg::DIV255_RECIP;
    end
  end

  assign q = prod3[cabp_pkg::DIV255_SHIFT +: 8];

endmodule

@@ hw/rtl/clipped_alpha_blend_pixel.sv @@
// ----------------------------------------------------------------------------
// clipped_alpha_blend_pixel
// Clip test and source-over blend of one ARGB8888 pixel write per cycle while out_px is ready.
// ----------------------------------------------------------------------------
// Usage:
//   in_px carries one pixel request word: signed position, source color and
//   the destination word currently stored at that position. out_px returns one
//   result word per request: write flag, framebuffer word index and pixel.
//   A dropped write (clipped, off-screen or fully transparent) comes back with
//   write_enable low and zero index and pixel.
//   Configuration goes through cfg_we/cfg_addr/cfg_data; the user must write it
//   only while no request is in flight, which the block itself does not enforce;
//   indexes above the register list are ignored.
//   Requests pass through a four-stage pipeline (three blend stages plus the
//   output register), each stage holding at most one multiply in depth;
//   throughput is one word per cycle while the receiver keeps ready high.
//   Reset clears all configuration registers and empties the pipeline.
//   When the receiver stalls, the output register holds its word and each
//   stage behind it keeps filling until its own slot is taken, so bubbles
//   close up before in_px.ready drops.
// ----------------------------------------------------------------------------
module clipped_alpha_blend_pixel (
  input  logic                          clk,
  input  logic                          rst,
  cabp_in_if.sink                       in_px,
  cabp_out_if.source                    out_px,
  input  logic                          cfg_we,
  input  logic [cabp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cabp_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic               clip_enable;
  logic signed [15:0] clip_left;
  logic signed [15:0] clip_top;
  logic [15:0]        clip_span_x;
  logic [15:0]        clip_span_y;
  logic [12:0]        fb_width;
  logic [12:0]        fb_height;
  logic [15:0]        fb_pitch_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable    <= 1'b0;
      clip_left      <= '0;
      clip_top       <= '0;
      clip_span_x    <= '0;
      clip_span_y    <= '0;
      fb_width       <= '0;
      fb_height      <= '0;
      fb_pitch_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cabp_pkg::REG_CLIP_ENABLE: clip_enable    <= cfg_data[0];
        cabp_pkg::REG_CLIP_LEFT:   clip_left      <= cfg_data;
        cabp_pkg::REG_CLIP_TOP:    clip_top       <= cfg_data;
        cabp_pkg::REG_CLIP_SPAN_X: clip_span_x    <= cfg_data;
        cabp_pkg::REG_CLIP_SPAN_Y: clip_span_y    <= cfg_data;
        cabp_pkg::REG_FB_WIDTH:    fb_width       <= cfg_data[12:0];
        cabp_pkg::REG_FB_HEIGHT:   fb_height      <= cfg_data[12:0];
        cabp_pkg::REG_FB_PITCH:    fb_pitch_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids; v4 is the output register
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;
  cabp_pkg::adv_t adv;

  // A stage advances when it is empty or the stage ahead advances
  assign adv4 = !v4 || out_px.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_px.ready = adv1;
  assign adv = '{s1: adv1, s2: adv2, s3: adv3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_px.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // Stage 1 decode: clip rectangle, framebuffer bounds, alpha
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [17:0] x_ext;
  logic signed [17:0] y_ext;
  logic signed [17:0] clip_right;
  logic signed [17:0] clip_bottom;
  logic               in_clip;
  logic               clip_ok;
  logic               fb_ok;
  logic [7:0]         alpha;
  logic               ok;
  logic [13:0]        stride;

  assign x     = in_px.pos_x;
  assign y     = in_px.pos_y;
  assign x_ext = {{2{x[15]}}, x};
  assign y_ext = {{2{y[15]}}, y};
  // edges are formed at 18 bits so a rectangle past 32767 is not cut short
  assign clip_right  = {{2{clip_left[15]}}, clip_left} + $signed({2'b00, clip_span_x});
  assign clip_bottom = {{2{clip_top[15]}}, clip_top} + $signed({2'b00, clip_span_y});
  assign in_clip = (x >= clip_left) && (x_ext < clip_right) &&
                   (y >= clip_top) && (y_ext < clip_bottom);
  assign clip_ok = !clip_enable || in_clip;
  assign fb_ok   = !x[15] && ({1'b0, x[14:0]} < {3'b000, fb_width}) &&
                   !y[15] && ({1'b0, y[14:0]} < {3'b000, fb_height});
  assign alpha   = in_px.src_color[31:24];
  assign ok      = clip_ok && fb_ok && (alpha != cabp_pkg::ALPHA_ZERO);
  assign stride  = fb_pitch_bytes[15:2];

  logic                         ok1, ok2, ok3;
  logic                         opq1, opq2, opq3;
  logic [31:0]                  src1, src2, src3;
  logic [12:0]                  x1;
  logic [cabp_pkg::INDEX_W-1:0] mul1;
  logic [cabp_pkg::INDEX_W-1:0] idx2, idx3;

  // Only in-range positions reach a write, so 13 bits of y and x suffice
  always_ff @(posedge clk) begin
    if (adv1) begin
      ok1  <= ok;
      opq1 <= (alpha == cabp_pkg::ALPHA_OPAQUE);
      src1 <= in_px.src_color;
      x1   <= x[12:0];
      mul1 <= {14'd0, y[12:0]} * {13'd0, stride};
    end
    if (adv2) begin
      ok2  <= ok1;
      opq2 <= opq1;
      src2 <= src1;
      idx2 <= mul1 + {14'd0, x1};
    end
    if (adv3) begin
      ok3  <= ok2;
      opq3 <= opq2;
      src3 <= src2;
      idx3 <= idx2;
    end
  end

  // Channel blend pipelines, aligned with stages 1 to 3
  logic [7:0] qr, qg, qb;

  cabp_chan u_chan_r (
    .clk (clk), .adv (adv),
    .s   (in_px.src_color[23:16]), .d (in_px.dst_pixel[23:16]), .a (alpha),
    .q   (qr)
  );

  cabp_chan u_chan_g (
    .clk (clk), .adv (adv),
    .s   (in_px.src_color[15:8]), .d (in_px.dst_pixel[15:8]), .a (alpha),
    .q   (qg)
  );

  cabp_chan u_chan_b (
    .clk (clk), .adv (adv),
    .s   (in_px.src_color[7:0]), .d (in_px.dst_pixel[7:0]), .a (alpha),
    .q   (qb)
  );

  // Output register: opaque source passes unchanged, blends write alpha 255
  logic [31:0]                  pix3;
  logic                         we4;
  logic [cabp_pkg::INDEX_W-1:0] idx4;
  logic [31:0]                  pix4;

  assign pix3 = opq3 ? src3 : {cabp_pkg::ALPHA_OPAQUE, qr, qg, qb};

  always_ff @(posedge clk) begin
    if (adv4) begin
      we4  <= ok3;
      idx4 <= ok3 ? idx3 : '0;
      pix4 <= ok3 ? pix3 : '0;
    end
  end

  assign out_px.valid        = v4;
  assign out_px.write_enable = we4;
  assign out_px.word_index   = idx4;
  assign out_px.out_pixel    = pix4;

endmodule

@@ hw/rtl/cabp_checker.sv @@
// ----------------------------------------------------------------------------
// cabp_checker
// Port-level checks of the clipped alpha blend pixel block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cabp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         write_enable,
  input logic [cabp_pkg::INDEX_W-1:0] word_index,
  input logic [31:0]                  out_pixel
);

  // hold a stalled result word
  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(word_index) && $stable(write_enable), "stalled result word changed")

  // drop carries zero index and pixel
  `ASSERT_RST(a_drop_zero, clk, rst, out_valid && !write_enable |-> word_index == '0 && out_pixel == '0, "dropped write carries data")

  // a written pixel never has zero alpha
  `ASSERT_RST(a_write_alpha, clk, rst, out_valid && write_enable |-> out_pixel[31:24] != 8'h00, "written pixel is transparent")

  // reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid right after reset")

endmodule

bind clipped_alpha_blend_pixel cabp_checker u_cabp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_px.valid),
  .out_ready    (out_px.ready),
  .write_enable (out_px.write_enable),
  .word_index   (out_px.word_index),
  .out_pixel    (out_px.out_pixel)
);

@@ bench/tb_clipped_alpha_blend_pixel.sv @@
// ----------------------------------------------------------------------------
// tb_clipped_alpha_blend_pixel
// Self-checking bench for the clipped alpha blend pixel block. Every request
// word accepted on in_px is run through a local predictor of the clip test,
// framebuffer bounds and source-over blend. The result goes into a queue and
// is compared field by field with the next word that leaves on out_px.
// ----------------------------------------------------------------------------
module tb_clipped_alpha_blend_pixel;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_PCT     = 22;    // percent of cycles a side sits idle
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 8;     // pipeline depth plus margin
  localparam int PHASE_WORDS  = 225;

  // One predicted pixel write, laid out like the out_px payload
  typedef struct packed {
    logic                         write_enable;
    logic [cabp_pkg::INDEX_W-1:0] word_index;
    logic [31:0]                  out_pixel;
  } pixel_write_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we;
  logic [cabp_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [cabp_pkg::CFG_DATA_W-1:0] cfg_data;

  cabp_in_if  in_px ();
  cabp_out_if out_px ();

  clipped_alpha_blend_pixel i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_px    (in_px),
    .out_px   (out_px),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Local copy of the configuration, held at full integer width so the clip
  // edge sums never wrap. Reset values match the block: everything zero.
  // --------------------------------------------------------------------------
  bit clip_on    = 1'b0;
  int clip_x0    = 0;
  int clip_y0    = 0;
  int clip_w     = 0;
  int clip_h     = 0;
  int fb_w       = 0;
  int fb_h       = 0;
  int fb_pitch   = 0;

  pixel_write_t pending_writes[$];   // predicted words, oldest first
  int           mismatches   = 0;
  int           quiet_cycles = 0;

  bit tx_idle_on   = 1'b1;   // sender inserts random gaps
  bit rx_idle_on   = 1'b1;   // receiver drops ready at random
  bit hold_request = 1'b0;   // ask the receiver for one long hold-off

  // Truncating source-over mix of one 8-bit channel.
  function automatic logic [7:0] blend_channel(input int s, input int d, input int a);
    int v;
    v = (s * a + d * (255 - a)) / 255;
    return v[7:0];
  endfunction

  // Predict the write caused by one request under the current configuration.
  function automatic pixel_write_t predict_write(input logic signed [15:0] px,
                                                 input logic signed [15:0] py,
                                                 input logic [31:0] src,
                                                 input logic [31:0] dst);
    pixel_write_t w;
    int           x, y, a;
    logic [31:0]  idx;
    bit           hit;
    x   = px;
    y   = py;
    a   = src[31:24];
    hit = 1'b1;
    w   = '0;
    // Clip rectangle: right and bottom edges are exclusive and unwrapped
    if (clip_on && !(x >= clip_x0 && x < clip_x0 + clip_w &&
                     y >= clip_y0 && y < clip_y0 + clip_h))
      hit = 1'b0;
    if (x < 0 || x >= fb_w || y < 0 || y >= fb_h)
      hit = 1'b0;
    if (src[31:24] == cabp_pkg::ALPHA_ZERO)
      hit = 1'b0;
    if (hit) begin
      // Row stride in words drops any odd bytes of the pitch
      idx            = y * (fb_pitch / 4) + x;
      w.write_enable = 1'b1;
      w.word_index   = idx[cabp_pkg::INDEX_W-1:0];
      if (src[31:24] == cabp_pkg::ALPHA_OPAQUE) begin
        w.out_pixel = src;
      end else begin
        // Destination alpha plays no part; blended words are always opaque
        w.out_pixel = {cabp_pkg::ALPHA_OPAQUE,
                       blend_channel(src[23:16], dst[23:16], a),
                       blend_channel(src[15:8],  dst[15:8],  a),
                       blend_channel(src[7:0],   dst[7:0],   a)};
      end
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on every accepted request word, check every accepted
  // result word. Both sample pre-edge values at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    pixel_write_t want;
    if (!rst && in_px.valid === 1'b1 && in_px.ready === 1'b1)
      pending_writes.push_back(predict_write(in_px.pos_x, in_px.pos_y,
                                             in_px.src_color, in_px.dst_pixel));
    if (!rst && out_px.valid === 1'b1 && out_px.ready === 1'b1) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word we=%b index=%h pixel=%h", $time,
                 out_px.write_enable, out_px.word_index, out_px.out_pixel);
      end else begin
        want = pending_writes.pop_front();
        if (out_px.write_enable !== want.write_enable) begin
          mismatches++;
          $display("%0t: write_enable expected %b actual %b", $time,
                   want.write_enable, out_px.write_enable);
        end
        if (out_px.word_index !== want.word_index) begin
          mismatches++;
          $display("%0t: word_index expected %h actual %h", $time,
                   want.word_index, out_px.word_index);
        end
        if (out_px.out_pixel !== want.out_pixel) begin
          mismatches++;
          $display("%0t: out_pixel expected %h actual %h", $time,
                   want.out_pixel, out_px.out_pixel);
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_px.valid && in_px.ready) || (out_px.valid && out_px.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_clipped_alpha_blend_pixel: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: drive ready at the falling edge. A hold request drops ready for
  // HOLD_CYCLES, counted here, so the pipeline fills and in_px stalls.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    out_px.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_px.ready <= 1'b0;
      end else begin
        out_px.ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge. After a word
  // is accepted valid stays high; the next call either offers a new word or
  // drops valid for a gap, so valid gets one assignment per edge.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [31:0] src, input logic [31:0] dst);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_px.valid <= 1'b0;
      @(negedge clk);
    end
    in_px.valid     <= 1'b1;
    in_px.pos_x     <= x;
    in_px.pos_y     <= y;
    in_px.src_color <= src;
    in_px.dst_pixel <= dst;
    do @(posedge clk); while (in_px.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_drained();
    in_px.valid <= 1'b0;
    do @(negedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic write_reg(input logic [cabp_pkg::CFG_ADDR_W-1:0] addr, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[cabp_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // Program all registers while the block is idle, poke one unused index,
  // then update the local copy.
  task automatic program_frame(input bit en, input int left, input int top,
                               input int span_x, input int span_y,
                               input int width, input int height, input int pitch);
    int spare_reg;
    wait_drained();
    write_reg(cabp_pkg::REG_CLIP_ENABLE, en);
    write_reg(cabp_pkg::REG_CLIP_LEFT,   left);
    write_reg(cabp_pkg::REG_CLIP_TOP,    top);
    write_reg(cabp_pkg::REG_CLIP_SPAN_X, span_x);
    write_reg(cabp_pkg::REG_CLIP_SPAN_Y, span_y);
    write_reg(cabp_pkg::REG_FB_WIDTH,    width);
    write_reg(cabp_pkg::REG_FB_HEIGHT,   height);
    write_reg(cabp_pkg::REG_FB_PITCH,    pitch);
    // Indexes above the register list must leave the configuration alone
    spare_reg = cabp_pkg::REG_FB_PITCH + 1 + int'($urandom_range(0, 7));
    write_reg(spare_reg[cabp_pkg::CFG_ADDR_W-1:0], $urandom);
    cfg_we   <= 1'b0;
    clip_on  = en;
    clip_x0  = $signed(left[15:0]);
    clip_y0  = $signed(top[15:0]);
    clip_w   = span_x[15:0];
    clip_h   = span_y[15:0];
    fb_w     = width[12:0];
    fb_h     = height[12:0];
    fb_pitch = pitch[15:0];
    @(negedge clk);
  endtask

  // Pick a coordinate a few pixels around [lo, lo+span).
  function automatic int near_range(input int lo, input int span);
    return lo - 3 + int'($urandom_range(0, span + 5));
  endfunction

  // Random request: mostly aimed at the clip window or the framebuffer so
  // that writes land, the rest anywhere in the 16-bit space. Alpha favors
  // the fully transparent and fully opaque cases.
  task automatic send_random_pixel();
    int          pick, x, y;
    logic [31:0] src;
    pick = $urandom_range(99);
    if (pick < 40 && clip_on) begin
      x = near_range(clip_x0, clip_w);
      y = near_range(clip_y0, clip_h);
    end else if (pick < 80) begin
      x = near_range(0, fb_w);
      y = near_range(0, fb_h);
    end else begin
      x = $urandom;
      y = $urandom;
    end
    src  = $urandom;
    pick = $urandom_range(99);
    if (pick < 15)
      src[31:24] = cabp_pkg::ALPHA_ZERO;
    else if (pick < 35)
      src[31:24] = cabp_pkg::ALPHA_OPAQUE;
    send_pixel(x[15:0], y[15:0], src, $urandom);
  endtask

  // Random frame: small framebuffers most of the time, occasionally the
  // largest; pitch near the row size or anything; clip window near the frame.
  task automatic program_random_frame();
    int w, h, pitch, left, top, sx, sy, pick;
    pick = $urandom_range(9);
    w = (pick < 7) ? $urandom_range(1, 200) : (pick < 9) ? $urandom_range(0, 8191) : 8191;
    pick = $urandom_range(9);
    h = (pick < 7) ? $urandom_range(1, 200) : (pick < 9) ? $urandom_range(0, 8191) : 8191;
    pitch = ($urandom_range(9) < 6) ? w * 4 + $urandom_range(0, 7) : $urandom_range(0, 65535);
    left  = ($urandom_range(4) != 0) ? near_range(-7, w + 14) : $urandom;
    top   = ($urandom_range(4) != 0) ? near_range(-7, h + 14) : $urandom;
    pick  = $urandom_range(9);
    sx = (pick < 7) ? $urandom_range(0, w + 10) : (pick < 8) ? 0 :
         (pick < 9) ? 65535 : $urandom_range(0, 65535);
    pick  = $urandom_range(9);
    sy = (pick < 7) ? $urandom_range(0, h + 10) : (pick < 8) ? 0 :
         (pick < 9) ? 65535 : $urandom_range(0, 65535);
    program_frame($urandom_range(1) != 0, left, top, sx, sy, w, h, pitch);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the framebuffer is 0 x 0, so every write is dropped.
  task automatic test_reset_state();
    send_pixel(0, 0, 32'hFF12_3456, 32'h0000_0000);
    repeat (7) send_random_pixel();
  endtask

  // Alpha cases and framebuffer edges, no clipping, pitch not a multiple of four.
  task automatic test_blend_cases();
    program_frame(1'b0, 0, 0, 0, 0, 64, 48, 258);
    send_pixel(0,      0,      32'hFF12_3456, 32'hABCD_EF01);  // opaque copy
    send_pixel(63,     47,     32'h80FF_FFFF, 32'h0000_0000);  // last pixel, blend
    send_pixel(64,     0,      32'hFF00_0000, 32'hFFFF_FFFF);  // one past right edge
    send_pixel(0,      48,     32'hFF00_0000, 32'hFFFF_FFFF);  // one past bottom edge
    send_pixel(-1,     5,      32'hFFFF_FFFF, 32'h0000_0000);  // negative x
    send_pixel(5,      -32768, 32'hFFFF_FFFF, 32'h0000_0000);  // most negative y
    send_pixel(32767,  32767,  32'hFFFF_FFFF, 32'h0000_0000);  // most positive
    send_pixel(10,     10,     32'h00FF_FFFF, 32'h1234_5678);  // transparent
    send_pixel(10,     11,     32'h0100_0000, 32'hFFFF_FFFF);  // faintest alpha
    send_pixel(10,     12,     32'hFEFF_FFFF, 32'h0000_0000);  // almost opaque
    send_pixel(1,      1,      32'h7F00_FF00, 32'h0000_00FF);  // dst alpha ignored
  endtask

  // Clip window edges, a window reaching past 32767, and an empty window.
  task automatic test_clip_edges();
    program_frame(1'b1, 10, 5, 20, 10, 64, 48, 256);
    send_pixel(10, 5,  32'hFF11_2233, 32'h0);  // top-left corner, inside
    send_pixel(29, 14, 32'hFF11_2233, 32'h0);  // bottom-right corner, inside
    send_pixel(9,  5,  32'hFF11_2233, 32'h0);  // left of window
    send_pixel(30, 5,  32'hFF11_2233, 32'h0);  // right of window
    send_pixel(10, 4,  32'hFF11_2233, 32'h0);  // above window
    send_pixel(10, 15, 32'hFF11_2233, 32'h0);  // below window
    // Right edge 8000 + 65535 would wrap below 8000 if cut to 16 bits
    program_frame(1'b1, 8000, -32768, 65535, 65535, 8191, 8191, 65535);
    send_pixel(8100, 8190, 32'h40A0_B0C0, 32'h1020_3040);
    send_pixel(8190, 0,    32'hFF55_AA55, 32'h0);
    // Zero span accepts nothing while clipping is on
    program_frame(1'b1, 0, 0, 0, 10, 64, 48, 256);
    send_pixel(0, 0, 32'hFF55_AA55, 32'h0);
  endtask

  // Corner settings of every register, with random requests.
  task automatic test_config_extremes();
    program_frame(1'b1, -32768, 32767, 65535, 65535, 8191, 8191, 0);
    repeat (20) send_random_pixel();
    program_frame(1'b0, 32767, -32768, 0, 0, 0, 0, 65535);
    repeat (20) send_random_pixel();
    program_frame(1'b1, 0, 0, 1, 1, 1, 1, 3);
    repeat (20) send_random_pixel();
    program_frame(1'b0, 0, 0, 0, 0, 8191, 1, 65535);
    repeat (20) send_random_pixel();
  endtask

  // Hold the receiver off while the sender keeps offering words so that
  // in_px.ready drops, then pause the sender until everything has drained.
  task automatic test_backpressure();
    program_frame(1'b0, 0, 0, 0, 0, 64, 48, 256);
    tx_idle_on   = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_pixel();
    wait_drained();
    repeat (20) send_random_pixel();
    tx_idle_on = 1'b1;
  endtask

  // Bulk random traffic over several random frames; one phase runs with no
  // idling on either side.
  task automatic test_random_stream();
    for (int phase = 0; phase < 6; phase++) begin
      program_random_frame();
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      repeat (PHASE_WORDS) send_random_pixel();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_px.valid     = 1'b0;
    in_px.pos_x     = '0;
    in_px.pos_y     = '0;
    in_px.src_color = '0;
    in_px.dst_pixel = '0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_data        = '0;

    // Hold reset for a few cycles, release it on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_blend_cases();
    test_clip_edges();
    test_config_extremes();
    test_backpressure();
    test_random_stream();

    // Drain, then watch a little longer for stray result words
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("tb_clipped_alpha_blend_pixel: PASS");
    else
      $display("tb_clipped_alpha_blend_pixel: FAIL");
    $finish;
  end

endmodule

@@ clipped_alpha_blend_pixel.f @@
+incdir+hw/rtl
hw/rtl/cabp_pkg.sv
hw/rtl/cabp_if.sv
hw/rtl/cabp_chan.sv
hw/rtl/clipped_alpha_blend_pixel.sv
hw/rtl/cabp_checker.sv
bench/tb_clipped_alpha_blend_pixel.sv
